@@ rtl/fragment_reassembly_tracker_unit_macros.svh @@
// Assertion macros used by the fragment reassembly tracker back end.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define FRT_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define FRT_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

@@ rtl/frt_pkg.sv @@
// Shared types and constants for the fragment reassembly tracker.
`default_nettype none

package frt_pkg;

  // Field widths fixed by the header format
  localparam int FRAME_W = 32;
  localparam int FIDX_W  = 16;
  localparam int FTOT_W  = 16;
  localparam int CNT_W   = 7;
  localparam int SLOT_OUT_W = 3;

  // Defaults for the top-level parameters
  localparam int DEF_FRAME_SLOTS   = 8;
  localparam int DEF_MAX_FRAGMENTS = 64;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Verdict codes
  typedef enum logic [2:0] {
    V_ACCEPT = 3'd0,
    V_DUP    = 3'd1,
    V_STALE  = 3'd2,
    V_SHORT  = 3'd3,
    V_BADIDX = 3'd4,
    V_NOSLOT = 3'd5,
    V_DONE   = 3'd6
  } verdict_t;

  // One classified fragment header as held in the queue
  typedef struct packed {
    logic [FRAME_W-1:0] frame_num;
    logic [FIDX_W-1:0]  frag_idx;
    logic [FTOT_W-1:0]  frag_tot;
    logic               short_hdr;  // header did not fit
    logic               new_bad;    // index/total invalid for a new frame
  } q_entry_t;

endpackage

`default_nettype wire

@@ rtl/frt_front.sv @@
// Front end: takes fragment headers, classifies them and queues them for the back end.
`default_nettype none

module frt_front #(
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [frt_pkg::FRAME_W-1:0] in_frame_num,
  input  wire logic [frt_pkg::FIDX_W-1:0]  in_fragment_index,
  input  wire logic [frt_pkg::FTOT_W-1:0]  in_fragment_total,
  input  wire logic                       in_header_ok,
  output logic                            q_valid,
  output frt_pkg::q_entry_t               q_entry,
  input  wire logic                       q_pop
);
  import frt_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  q_entry_t            q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   cnt_r, cnt_nxt;
  logic                push;
  q_entry_t            new_entry;

  assign busy    = (cnt_r == CNT_QW'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_entry = q_mem_r[rd_ptr_r];

  // Classify the header checks that need no table state
  always_comb begin
    new_entry.frame_num = in_frame_num;
    new_entry.frag_idx  = in_fragment_index;
    new_entry.frag_tot  = in_fragment_total;
    new_entry.short_hdr = !in_header_ok;
    new_entry.new_bad   = (in_fragment_total == '0) ||
                          (in_fragment_total > FTOT_W'(MAX_FRAGMENTS)) ||
                          (in_fragment_index >= in_fragment_total);
  end

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop && q_valid})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

`default_nettype wire

@@ rtl/frt_back.sv @@
// Back end: slot table lookup, update, completion sweep and verdict register.
`default_nettype none

`include "fragment_reassembly_tracker_unit_macros.svh"

module frt_back #(
  parameter int FRAME_SLOTS   = frt_pkg::DEF_FRAME_SLOTS,
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire frt_pkg::q_entry_t              q_entry,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [2:0]                          out_verdict,
  output logic [frt_pkg::SLOT_OUT_W-1:0]      out_slot_used,
  output logic [frt_pkg::FRAME_W-1:0]         out_frame_out,
  output logic [frt_pkg::CNT_W-1:0]           out_received_now
);
  import frt_pkg::*;

  localparam int SW  = $clog2(FRAME_SLOTS);
  localparam int MIW = $clog2(MAX_FRAGMENTS);

  // Slot table
  logic [FRAME_SLOTS-1:0]   valid_r, valid_nxt;
  logic [FRAME_W-1:0]       frame_r [FRAME_SLOTS];
  logic [CNT_W-1:0]         exp_r   [FRAME_SLOTS];
  logic [CNT_W-1:0]         rcv_r   [FRAME_SLOTS];
  logic [MAX_FRAGMENTS-1:0] map_r   [FRAME_SLOTS];
  logic [FRAME_W-1:0]       last_done_r;

  // Output register
  logic                     out_valid_r;
  verdict_t                 out_verdict_r;
  logic [SLOT_OUT_W-1:0]    out_slot_r;
  logic [FRAME_W-1:0]       out_frame_r;
  logic [CNT_W-1:0]         out_rcv_r;

  // Lookup and decision
  logic                     hit_found, free_found;
  logic [SW-1:0]            hit_sel, free_sel, slot_sel;
  logic                     stale;
  logic [CNT_W-1:0]         cur_exp, cur_rcv, new_rcv;
  logic [MAX_FRAGMENTS-1:0] cur_map, new_map;
  logic [MIW-1:0]           bit_idx;
  logic                     dup, done, write_en;
  verdict_t                 verdict;
  logic [SLOT_OUT_W-1:0]    res_slot;
  logic [CNT_W-1:0]         res_cnt;

  // Result classes watched by the checks below
  logic                     out_drop;
  logic                     out_done;

  assign q_pop = q_valid;

  // Search for the frame's slot and the lowest free slot
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_sel    = '0;
    free_sel   = '0;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (valid_r[i] && (frame_r[i] == q_entry.frame_num) && !hit_found) begin
        hit_found = 1'b1;
        hit_sel   = SW'(i);
      end
      if (!valid_r[i] && !free_found) begin
        free_found = 1'b1;
        free_sel   = SW'(i);
      end
    end
  end

  // Slot contents as seen by this fragment
  always_comb begin
    slot_sel = hit_found ? hit_sel : free_sel;
    stale    = (last_done_r != '0) && (q_entry.frame_num <= last_done_r);
    cur_exp  = hit_found ? exp_r[hit_sel] : CNT_W'(q_entry.frag_tot);
    cur_rcv  = hit_found ? rcv_r[hit_sel] : '0;
    cur_map  = hit_found ? map_r[hit_sel] : '0;
    bit_idx  = q_entry.frag_idx[MIW-1:0];
    dup      = cur_map[bit_idx];
    new_map  = cur_map;
    new_map[bit_idx] = 1'b1;
    new_rcv  = cur_rcv + 1'b1;
    done     = (new_rcv == cur_exp);
  end

  // Verdict priority
  always_comb begin
    verdict  = V_ACCEPT;
    write_en = 1'b0;
    res_slot = '0;
    res_cnt  = '0;
    if (q_entry.short_hdr) begin
      verdict = V_SHORT;
    end else if (stale) begin
      verdict = V_STALE;
    end else if (hit_found && (q_entry.frag_idx >= FIDX_W'(cur_exp))) begin
      verdict = V_BADIDX;
    end else if (!hit_found && q_entry.new_bad) begin
      verdict = V_BADIDX;
    end else if (!hit_found && !free_found) begin
      verdict = V_NOSLOT;
    end else if (dup) begin
      verdict  = V_DUP;
      res_slot = SLOT_OUT_W'(slot_sel);
      res_cnt  = cur_rcv;
    end else begin
      verdict  = done ? V_DONE : V_ACCEPT;
      write_en = 1'b1;
      res_slot = SLOT_OUT_W'(slot_sel);
      res_cnt  = new_rcv;
    end
  end

  // Valid bits: allocate, or sweep out every frame at or below a completed one
  always_comb begin
    valid_nxt = valid_r;
    if (q_pop && write_en) begin
      if (done) begin
        for (int i = 0; i < FRAME_SLOTS; i++) begin
          if (valid_r[i] && (frame_r[i] <= q_entry.frame_num)) begin
            valid_nxt[i] = 1'b0;
          end
        end
      end else begin
        valid_nxt[slot_sel] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      last_done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= q_pop;
      if (q_pop && write_en && done) begin
        last_done_r <= q_entry.frame_num;
      end
    end
  end

  // Slot payload, only meaningful while valid
  always_ff @(posedge clk) begin
    if (q_pop && write_en) begin
      frame_r[slot_sel] <= q_entry.frame_num;
      exp_r[slot_sel]   <= cur_exp;
      rcv_r[slot_sel]   <= new_rcv;
      map_r[slot_sel]   <= new_map;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_verdict_r <= verdict;
      out_slot_r    <= res_slot;
      out_frame_r   <= q_entry.frame_num;
      out_rcv_r     <= res_cnt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_slot_used    = out_slot_r;
  assign out_frame_out    = out_frame_r;
  assign out_received_now = out_rcv_r;

  // Drop and completion results on the output register
  assign out_drop = out_valid_r &&
                    (out_verdict_r == V_STALE || out_verdict_r == V_SHORT ||
                     out_verdict_r == V_BADIDX || out_verdict_r == V_NOSLOT);
  assign out_done = out_valid_r && (out_verdict_r == V_DONE);

  // Every queue pop yields exactly one result on the next cycle
  `FRT_ASSERT_NXT(a_pop_gives_result, q_pop, out_valid_r, "pop without result")
  // Dropped fragments carry no slot and no count
  `FRT_ASSERT_IMP(a_drop_zero, out_drop, out_slot_r == '0 && out_rcv_r == '0, "drop with data")
  // A completion verdict is reflected in the last completed frame id
  `FRT_ASSERT_IMP(a_done_tracks_last, out_done, last_done_r == out_frame_r, "done not recorded")

endmodule

`default_nettype wire

@@ rtl/fragment_reassembly_tracker_unit.sv @@
// An accepted header is queued in the front end, then popped into the output verdict register.
// Throughput: one header per cycle; the back end pops each queue entry the cycle after
// it is written, so the queue never holds more than one entry and busy never rises.
// Each verdict shows for exactly one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue, frees all slots and clears the
// last completed frame id; no clearing pass is needed afterward.
`default_nettype none

module fragment_reassembly_tracker_unit #(
  parameter int FRAME_SLOTS   = frt_pkg::DEF_FRAME_SLOTS,
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [frt_pkg::FRAME_W-1:0]   in_frame_num,
  input  wire logic [frt_pkg::FIDX_W-1:0]    in_fragment_index,
  input  wire logic [frt_pkg::FTOT_W-1:0]    in_fragment_total,
  input  wire logic                          in_header_ok,
  output logic                               out_valid,
  output logic [2:0]                         out_verdict,
  output logic [frt_pkg::SLOT_OUT_W-1:0]     out_slot_used,
  output logic [frt_pkg::FRAME_W-1:0]        out_frame_out,
  output logic [frt_pkg::CNT_W-1:0]          out_received_now
);
  import frt_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  // Header intake and queue
  frt_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_frame_num      (in_frame_num),
    .in_fragment_index (in_fragment_index),
    .in_fragment_total (in_fragment_total),
    .in_header_ok      (in_header_ok),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .q_pop             (q_pop)
  );

  // Slot table and verdicts
  frt_back #(
    .FRAME_SLOTS   (FRAME_SLOTS),
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_verdict      (out_verdict),
    .out_slot_used    (out_slot_used),
    .out_frame_out    (out_frame_out),
    .out_received_now (out_received_now)
  );

endmodule

`default_nettype wire
